@@ hw/rtl/byte_substring_search_macros.svh @@
// Assertion macros for the checker file of the substring search block.
// No dependencies; take in with `include where assertions are written.
`ifndef BYTE_SUBSTRING_SEARCH_MACROS_SVH
`define BYTE_SUBSTRING_SEARCH_MACROS_SVH

// Same-cycle implication, quiet during reset
`define BSS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bss assertion failed");

// Next-cycle implication, quiet during reset
`define BSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bss assertion failed");

`endif

@@ hw/rtl/bss_pkg.sv @@
// Shared types, constants and the per-position byte compare of the substring search.
// No dependencies; used by the design modules through scoped names.
package bss_pkg;

  // Needle storage is fixed by the two 64-bit needle registers
  localparam int NEEDLE_W   = 128;
  localparam int LEN_W      = 5;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 64;
  localparam int RES_OFF_W  = 32;

  // Register indexes (paddr[4:3])
  localparam logic [1:0] REG_NEEDLE_LENGTH = 2'd0;
  localparam logic [1:0] REG_NEEDLE_LOW    = 2'd1;
  localparam logic [1:0] REG_NEEDLE_HIGH   = 2'd2;

  // One result transaction
  typedef struct packed {
    logic                 found;
    logic [RES_OFF_W-1:0] match_offset;
  } res_t;

  // Byte at window position pos (0 = newest) against needle byte len-1-pos.
  // Positions at or beyond the needle length always pass.
  function automatic logic pos_ok(input logic [LEN_W-1:0]    pos,
                                  input logic [LEN_W-1:0]    len,
                                  input logic [7:0]          d,
                                  input logic [NEEDLE_W-1:0] needle);
    logic [LEN_W-1:0] idx;
    idx = len - pos - 5'd1;
    if (pos >= len) begin
      return 1'b1;
    end
    return d == needle[{idx[3:0], 3'b000} +: 8];
  endfunction

endpackage

@@ hw/rtl/byte_substring_search.sv @@
// Top level of the streaming substring search: config registers, cell chain, result buffer.
// Depends on bss_pkg, bss_cell, bss_out_buf.
//
//  channel   | direction | payload                              | done when
//  ----------+-----------+--------------------------------------+-------------------------
//  s_axis    | in        | tdata[7:0] haystack_byte, tlast      | tvalid & tready
//  m_axis    | out       | tdata[31:0] match_offset, tuser found| tvalid & tready
//  apb       | in        | pwdata 64b, paddr 8*index            | psel & penable & pwrite
//
// One haystack byte per cycle; s_axis_tready drops only while both result buffer entries
// wait. The whole window compare against the needle is combinational, parallel byte
// compares in the cell chain, and a result is pushed into the result buffer with its byte.
// Synchronous reset clears registers, history, the byte count and the buffer.
module byte_substring_search #(
  parameter int NEEDLE_MAX  = 16,
  parameter int OFFSET_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  // haystack stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] haystack_byte
  input  logic                          s_axis_tlast,   // last_byte
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [31:0]                   m_axis_tdata,   // [31:0] match_offset
  output logic                          m_axis_tuser,   // [0] found
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bss_pkg::ADDR_W-1:0]    paddr,
  input  logic [bss_pkg::DATA_W-1:0]    pwdata,
  output logic [bss_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  logic [bss_pkg::LEN_W-1:0]    needle_length;
  logic [63:0]                  needle_low;
  logic [63:0]                  needle_high;
  logic [bss_pkg::NEEDLE_W-1:0] needle;
  logic [bss_pkg::LEN_W-1:0]    len_eff;
  logic [bss_pkg::LEN_W-1:0]    len_m1;
  logic                         cfg_wr;

  logic [NEEDLE_MAX-1:0][7:0]   chain;
  logic [NEEDLE_MAX-1:0]        ok;

  logic                         accept;
  logic [OFFSET_BITS-1:0]       bytes_seen;
  logic [OFFSET_BITS-1:0]       bytes_seen_next;
  logic [OFFSET_BITS-1:0]       diff;
  logic                         match_reported;
  logic                         match_reported_next;
  logic                         seen_ok;
  logic                         hit;
  logic [31:0]                  off32;
  logic                         push;
  logic                         buf_full;
  bss_pkg::res_t                res;
  bss_pkg::res_t                res_out;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      needle_length <= '0;
      needle_low    <= '0;
      needle_high   <= '0;
    end else if (cfg_wr) begin
      case (paddr[4:3])
        bss_pkg::REG_NEEDLE_LENGTH: needle_length <= pwdata[bss_pkg::LEN_W-1:0];
        bss_pkg::REG_NEEDLE_LOW:    needle_low    <= pwdata;
        bss_pkg::REG_NEEDLE_HIGH:   needle_high   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      bss_pkg::REG_NEEDLE_LENGTH: prdata = {{(bss_pkg::DATA_W-bss_pkg::LEN_W){1'b0}},
                                            needle_length};
      bss_pkg::REG_NEEDLE_LOW:    prdata = needle_low;
      bss_pkg::REG_NEEDLE_HIGH:   prdata = needle_high;
      default:                    prdata = '0;
    endcase
  end

  // Lengths beyond the window act as the full window
  assign needle  = {needle_high, needle_low};
  assign len_eff = (needle_length > bss_pkg::LEN_W'(NEEDLE_MAX))
                   ? bss_pkg::LEN_W'(NEEDLE_MAX) : needle_length;
  assign len_m1  = len_eff - 5'd1;

  assign accept = s_axis_tvalid & s_axis_tready;

  // Cell chain: position 0 is the incoming byte, position k the k-th older one
  assign chain[0] = s_axis_tdata;

  for (genvar k = 0; k < NEEDLE_MAX - 1; k++) begin : g_cell
    bss_cell #(.POS(k)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .shift  (accept),
      .clear  (s_axis_tlast),
      .len    (len_eff),
      .needle (needle),
      .din    (chain[k]),
      .dout   (chain[k+1]),
      .ok     (ok[k])
    );
  end

  // Oldest position has no successor, so only its compare is needed
  assign ok[NEEDLE_MAX-1] = bss_pkg::pos_ok(bss_pkg::LEN_W'(NEEDLE_MAX - 1), len_eff,
                                            chain[NEEDLE_MAX-1], needle);

  // Match decision
  assign seen_ok = (len_eff == '0) || (bytes_seen >= OFFSET_BITS'(len_m1));
  assign hit     = !match_reported && seen_ok && (&ok);
  assign diff    = bytes_seen - OFFSET_BITS'(len_m1);

  if (OFFSET_BITS > 32) begin : g_off_sat
    assign off32 = (|diff[OFFSET_BITS-1:32]) ? 32'hFFFF_FFFF : diff[31:0];
  end else begin : g_off_ext
    assign off32 = 32'(diff);
  end

  assign res.found        = hit;
  assign res.match_offset = (hit && len_eff != '0) ? off32 : 32'd0;
  assign push             = accept && (hit || (s_axis_tlast && !match_reported));

  // Per-haystack state
  always_comb begin
    bytes_seen_next     = bytes_seen;
    match_reported_next = match_reported;
    if (accept) begin
      if (s_axis_tlast) begin
        bytes_seen_next     = '0;
        match_reported_next = 1'b0;
      end else begin
        match_reported_next = match_reported | hit;
        if (bytes_seen != '1) begin
          bytes_seen_next = bytes_seen + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen     <= '0;
      match_reported <= 1'b0;
    end else begin
      bytes_seen     <= bytes_seen_next;
      match_reported <= match_reported_next;
    end
  end

  // Result buffer
  bss_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din       (res),
    .full      (buf_full),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .dout      (res_out)
  );

  assign s_axis_tready = !buf_full;
  assign m_axis_tdata  = res_out.match_offset;
  assign m_axis_tuser  = res_out.found;

endmodule

@@ hw/rtl/bss_cell.sv @@
// One window cell: holds a history byte, hands it to the next cell, compares its input.
// Depends on bss_pkg (pos_ok, widths).
module bss_cell #(
  parameter int POS = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          shift,
  input  logic                          clear,
  input  logic [bss_pkg::LEN_W-1:0]     len,
  input  logic [bss_pkg::NEEDLE_W-1:0]  needle,
  input  logic [7:0]                    din,
  output logic [7:0]                    dout,
  output logic                          ok
);

  logic [7:0] held;

  // History byte moves one place older on every accepted transaction; clear zeroes it instead
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 8'd0;
    end else if (shift) begin
      held <= clear ? 8'd0 : din;
    end
  end

  assign dout = held;

  // Compare the byte that sits at this position for the current transaction
  assign ok = bss_pkg::pos_ok(bss_pkg::LEN_W'(POS), len, din, needle);

endmodule

@@ hw/rtl/bss_out_buf.sv @@
// Two-entry result buffer that decouples result handoff from input acceptance.
// Depends on bss_pkg (res_t).
module bss_out_buf (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bss_pkg::res_t  din,
  output logic           full,
  output logic           out_valid,
  input  logic           out_ready,
  output bss_pkg::res_t  dout
);

  bss_pkg::res_t ent [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    cnt;
  logic          pop;

  assign pop       = out_valid & out_ready;
  assign full      = (cnt == 2'd2);
  assign out_valid = (cnt != 2'd0);
  assign dout      = ent[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= din;
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ hw/rtl/bss_checker.sv @@
// Port-level checks for byte_substring_search, attached by bind.
// Depends on byte_substring_search_macros.svh.
`include "byte_substring_search_macros.svh"

module bss_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // Stalled result transaction holds
  `BSS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // A not-found result carries a zero offset
  `BSS_ASSERT_IMPL(a_miss_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 32'd0)

  // Nothing is pending right after reset
  `BSS_ASSERT_IMPL(a_reset_empty, $past(rst), !m_axis_tvalid)

  // With no result waiting, input is never back-pressured
  `BSS_ASSERT_IMPL(a_empty_ready, !m_axis_tvalid, s_axis_tready)

endmodule

bind byte_substring_search bss_checker u_bss_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
